@@ hw/rtl/fpsqrt_pkg.sv @@
// Shared constants and types for the fixed-point square root block.
// No dependencies; imported by fpsqrt_step and fixed_point_square_root.
package fpsqrt_pkg;

  localparam int RADICAND_W = 64;  // raw Q51.12 input word
  localparam int ROOT_W     = 38;  // raw root output word
  localparam int CORE_W     = 32;  // integer root of a value below 2^63
  localparam int REM_W      = CORE_W + 2;
  localparam int CNT_W      = $clog2(CORE_W);

  // Partial remainder and partial root carried between iterations.
  typedef struct packed {
    logic [REM_W-1:0]  rem;
    logic [CORE_W-1:0] root;
  } step_t;

endpackage

@@ hw/rtl/fixed_point_square_root.sv @@
// Top level of the Q51.12 fixed-point square root: sequencer, work registers
// and output register around the shared digit unit. Depends on fpsqrt_pkg, fpsqrt_step.
//
// Usage:
//   Input channel (in_valid_i / in_ready_o / radicand_i) takes one signed
//   64-bit raw word with 12 fraction bits. Output channel (out_valid_o /
//   out_ready_i / root_o / negative_input_o) returns one word per input:
//   the floor integer square root of the raw value shifted left by
//   HALF_FRACTION_BITS, truncated to 38 bits.
//   Zero gives a root of 0; a negative word gives a root of 0 with
//   negative_input_o set.
// Timing:
//   One digit unit resolves one root bit per cycle, the 32 root bits of a
//   word in turn, then the result moves into the output register. The next
//   word is accepted only once the last has moved there; in_ready_o is
//   high only while the sequencer is idle.
// Stall and reset:
//   The output register holds a finished word until taken. While it is
//   occupied the next word may be accepted and computed; its result then
//   waits in the work registers until the output register frees.
//   Reset (rst_ni low, asynchronous) empties the output register and
//   returns the sequencer to idle; no state survives between words.
module fixed_point_square_root
  import fpsqrt_pkg::*;
#(
  parameter int HALF_FRACTION_BITS = 6
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  logic [RADICAND_W-1:0] radicand_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output logic [ROOT_W-1:0]     root_o,
  output logic                  negative_input_o
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_RUN  = 2'd1;
  localparam logic [1:0] ST_HOLD = 2'd2;

  logic [1:0]            state_q, state_d;
  logic [CNT_W-1:0]      cnt_q, cnt_d;
  logic [RADICAND_W-1:0] x_q, x_d;      // radicand, consumed two bits at a time
  step_t                 work_q, work_d;
  logic                  neg_q, neg_d;
  logic                  out_valid_q, out_valid_d;
  logic [ROOT_W-1:0]     root_q, root_d;
  logic                  oneg_q, oneg_d;

  step_t                 step_nxt;
  logic                  in_fire;
  logic                  out_free;
  logic [2*CORE_W-1:0]   wide_root;

  fpsqrt_step u_step (
    .cur_i  (work_q),
    .pair_i (x_q[RADICAND_W-1 -: 2]),
    .nxt_o  (step_nxt)
  );

  assign in_ready_o = (state_q == ST_IDLE);
  assign in_fire    = in_valid_i && in_ready_o;
  assign out_free   = !out_valid_q || out_ready_i;

  // scale the integer root back to fixed point; wraps to 38 bits
  assign wide_root = {{CORE_W{1'b0}}, work_q.root} << HALF_FRACTION_BITS;

  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    x_d         = x_q;
    work_d      = work_q;
    neg_d       = neg_q;
    out_valid_d = out_valid_q;
    root_d      = root_q;
    oneg_d      = oneg_q;

    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      ST_IDLE: begin
        if (in_fire) begin
          neg_d  = radicand_i[RADICAND_W-1];
          // a negative word runs as zero so the root comes out as zero
          x_d    = radicand_i[RADICAND_W-1] ? '0 : radicand_i;
          work_d = '0;
          cnt_d  = '0;
          state_d = ST_RUN;
        end
      end
      ST_RUN: begin
        work_d = step_nxt;
        x_d    = {x_q[RADICAND_W-3:0], 2'b00};
        cnt_d  = cnt_q + 1'b1;
        if (cnt_q == CNT_W'(CORE_W - 1)) begin
          state_d = ST_HOLD;
        end
      end
      ST_HOLD: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          root_d      = wide_root[ROOT_W-1:0];
          oneg_d      = neg_q;
          state_d     = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    x_q    <= x_d;
    work_q <= work_d;
    neg_q  <= neg_d;
    root_q <= root_d;
    oneg_q <= oneg_d;
  end

  assign out_valid_o      = out_valid_q;
  assign root_o           = root_q;
  assign negative_input_o = oneg_q;

  // a negative word never reports a nonzero root
  a_neg_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && negative_input_o) |-> (root_o == '0))
    else $error("negative input produced nonzero root");

  // an accepted word starts the digit sequence from its first step
  a_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire |=> (state_q == ST_RUN && cnt_q == '0 && work_q == '0))
    else $error("sequencer did not start cleanly");

  // partial root holds no more bits than steps taken
  a_root_width: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_RUN) |-> ((work_q.root >> cnt_q) == '0))
    else $error("partial root too wide");

  // restoring invariant: remainder never exceeds twice the partial root
  a_rem_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_RUN) |-> (work_q.rem <= {1'b0, work_q.root, 1'b0}))
    else $error("remainder out of bound");

  // a finished word is not overwritten before it is taken
  a_no_overrun: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !out_ready_i) |=> out_valid_q)
    else $error("output word dropped");

endmodule

@@ hw/rtl/fpsqrt_step.sv @@
// One restoring digit of the square root: brings in two radicand bits,
// trial-subtracts and appends one root bit. Depends on fpsqrt_pkg.
module fpsqrt_step
  import fpsqrt_pkg::*;
(
  input  step_t      cur_i,
  input  logic [1:0] pair_i,
  output step_t      nxt_o
);

  logic [REM_W-1:0] shifted;
  logic [REM_W-1:0] trial;
  logic [REM_W-1:0] diff;
  logic             fits;

  // top two remainder bits are zero by the rem <= 2*root invariant
  assign shifted = {cur_i.rem[REM_W-3:0], pair_i};
  assign trial   = {cur_i.root, 2'b01};
  assign diff    = shifted - trial;
  assign fits    = (shifted >= trial);

  assign nxt_o.rem  = fits ? diff : shifted;
  assign nxt_o.root = {cur_i.root[CORE_W-2:0], fits};

endmodule
